// File: sv/bounded_deque_with_search_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque with search
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_DEFINES_SVH

// A condition that must hold at every clock edge.
`define DQS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// A condition that implies another at the same clock edge.
`define DQS_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

// File: sv/dqs_pkg.sv
// ----------------------------------------------------------------------------
// Deque with search package
// Field widths, command and status codes, and the cell control word.
// ----------------------------------------------------------------------------
package dqs_pkg;

  localparam int CMD_W          = 3;
  localparam int VAL_W          = 32;
  localparam int POS_W          = 6;
  localparam int ST_W           = 3;
  localparam int CNT_W          = 7;
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4,
    CMD_READ_AT    = 3'd5
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REDUCE
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT_IN,
    OP_SHIFT_OUT,
    OP_WRITE
  } cell_op_t;

  typedef struct packed {
    logic     exec;
    cell_op_t op;
    logic     search_en;
    logic     read_en;
  } cell_ctl_t;

endpackage

// File: sv/dqs_if.sv
// ----------------------------------------------------------------------------
// Deque with search channels
// Valid/ready interfaces for the command word and the result word.
// ----------------------------------------------------------------------------
interface dqs_in_if import dqs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink (input valid, input cmd, input value, input position, output ready);
endinterface

interface dqs_out_if import dqs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] read_value;
  logic [CNT_W-1:0]        count;

  modport source (output valid, output status, output read_value, output count, input ready);
  modport sink (input valid, input status, input read_value, input count, output ready);
endinterface

// File: sv/dqs_cell.sv
// ----------------------------------------------------------------------------
// Deque storage cell
// Holds one entry, shifts with its neighbours and flags search and read hits.
// ----------------------------------------------------------------------------
module dqs_cell import dqs_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int IDX        = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cell_ctl_t                     ctl,
  input  logic [DATA_WIDTH-1:0]         left_data,
  input  logic [DATA_WIDTH-1:0]         right_data,
  input  logic [DATA_WIDTH-1:0]         value,
  input  logic [$clog2(DEPTH+1)-1:0]    count,
  input  logic [$clog2(DEPTH)-1:0]      pos,
  output logic [DATA_WIDTH-1:0]         data,
  output logic                          hit,
  output logic                          sel
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [IW-1:0] IDX_I = IW'(IDX);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  hit_r, hit_nxt;
  logic                  sel_r, sel_nxt;
  logic                  occupied;

  always_comb begin
    occupied = IDX_C < count;
    case (ctl.op)
      OP_SHIFT_IN:  data_nxt = left_data;
      OP_SHIFT_OUT: data_nxt = right_data;
      OP_WRITE:     data_nxt = (count == IDX_C) ? value : data_r;
      default:      data_nxt = data_r;
    endcase
    hit_nxt = ctl.exec ? (ctl.search_en && occupied && (data_r == value)) : hit_r;
    sel_nxt = ctl.exec ? (ctl.read_en && (pos == IDX_I)) : sel_r;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      hit_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
      sel_r <= sel_nxt;
    end
  end

  assign data = data_r;
  assign hit  = hit_r;
  assign sel  = sel_r;

endmodule

// File: sv/bounded_deque_with_search_top.sv
// ----------------------------------------------------------------------------
// Bounded deque with search
// Double-ended queue of signed values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Commands arrive as words on in_chan: push front, push back, pop front,
// pop back, search for a value, or read the entry at a position counted
// from the front. Every command gives exactly one result word on out_chan
// carrying a status, a read value and the entry count after the command.
// A command is accepted in the idle state, then passes through an execute
// step, in which every cell shifts, holds, writes or compares at once, and
// a reduce step, which gathers the search hits and the selected entry
// across the row of cells into the output register, where the result then
// stands valid. in_chan is ready only in the idle state, so a new command
// is accepted only once the last one has left the reduce step. Reset
// empties the queue; the stored entries are left undefined and are never
// read before they are written. While the receiver stalls, the result
// word is held, one further command may be accepted and executed, and its
// result waits until the output register is free.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_search_top_defines.svh"

module bounded_deque_with_search_top import dqs_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dqs_in_if.sink    in_chan,
  dqs_out_if.source out_chan
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int EW = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

  state_t                state_r, state_nxt;
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [DATA_WIDTH-1:0] value_r, value_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  status_t               status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [VAL_W-1:0]      out_rd_r, out_rd_nxt;
  logic [CNT_W-1:0]      out_count_r, out_count_nxt;

  cell_ctl_t             ctl;
  logic signed [EW-1:0]  in_ext;
  logic signed [EW-1:0]  rd_ext;
  logic                  full, empty, pos_ok, accept, load_out;
  logic [IW-1:0]         cell_pos;
  logic [DATA_WIDTH-1:0] data_w  [DEPTH];
  logic [DATA_WIDTH-1:0] left_w  [DEPTH];
  logic [DATA_WIDTH-1:0] right_w [DEPTH];
  logic [DEPTH-1:0]      hit_w, sel_w;
  logic                  hit_any;
  logic [DATA_WIDTH-1:0] rd_or;

  assign in_ext   = EW'(signed'(in_chan.value));
  assign rd_ext   = EW'(signed'(rd_or));
  assign full     = count_r == CW'(DEPTH);
  assign empty    = count_r == '0;
  assign pos_ok   = PW'(pos_r) < PW'(count_r);
  assign cell_pos = IW'(pos_r);
  assign accept   = in_chan.valid && in_chan.ready;
  assign load_out = (state_r == S_REDUCE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    value_nxt      = value_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    ctl            = '0;
    in_chan.ready  = 1'b0;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    out_count_nxt  = out_count_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    unique case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (accept) begin
          cmd_nxt   = in_chan.cmd;
          value_nxt = in_ext[DATA_WIDTH-1:0];
          pos_nxt   = in_chan.position;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        status_nxt = ST_OK;
        unique case (cmd_r)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              ctl.op    = (cmd_r == CMD_PUSH_FRONT) ? OP_SHIFT_IN : OP_WRITE;
              count_nxt = count_r + 1'b1;
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK: begin
            if (empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              ctl.op    = (cmd_r == CMD_POP_FRONT) ? OP_SHIFT_OUT : OP_HOLD;
              count_nxt = count_r - 1'b1;
            end
          end
          CMD_SEARCH: begin
            ctl.search_en = 1'b1;
          end
          CMD_READ_AT: begin
            ctl.read_en = pos_ok;
            status_nxt  = pos_ok ? ST_OK : ST_BAD_POS;
          end
          default: begin
          end
        endcase
        state_nxt = S_REDUCE;
      end
      S_REDUCE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = CNT_W'(count_r);
          if (cmd_r == CMD_SEARCH) begin
            out_status_nxt = hit_any ? ST_OK : ST_NOT_FOUND;
          end else begin
            out_status_nxt = status_r;
          end
          if (cmd_r == CMD_READ_AT) begin
            out_rd_nxt = (status_r == ST_OK) ? rd_ext[VAL_W-1:0] : '1;
          end else begin
            out_rd_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    value_r      <= value_nxt;
    pos_r        <= pos_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_count_r  <= out_count_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_front
      assign left_w[g] = value_r;
    end else begin : g_inner_l
      assign left_w[g] = data_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_back
      assign right_w[g] = data_w[g];
    end else begin : g_inner_r
      assign right_w[g] = data_w[g+1];
    end

    dqs_cell #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_data  (left_w[g]),
      .right_data (right_w[g]),
      .value      (value_r),
      .count      (count_r),
      .pos        (cell_pos),
      .data       (data_w[g]),
      .hit        (hit_w[g]),
      .sel        (sel_w[g])
    );
  end

  always_comb begin
    hit_any = |hit_w;
    rd_or   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | (sel_w[i] ? data_w[i] : '0);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.read_value = out_rd_r;
  assign out_chan.count      = out_count_r;

  `DQS_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH), "entry count exceeds depth")
  `DQS_ASSERT_IMP(a_count_step, count_r != $past(count_r), $past(state_r) == S_EXEC, "count moved outside execute")
  `DQS_ASSERT_IMP(a_out_rise, $rose(out_valid_r), $past(state_r) == S_REDUCE, "result appeared outside reduce")
  `DQS_ASSERT_IMP(a_one_select, state_r == S_REDUCE, $onehot0(sel_w), "more than one cell selected for read")

endmodule
